// ===== design/obpvg_pkg.sv =====
package obpvg_pkg;

  localparam int CMD_W      = 32;
  localparam int NUM_AXES   = 6;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_FRONT = 2'd1,
    KIND_BACK  = 2'd2,
    KIND_CMD   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REASON_FORWARD = 2'd0,
    REASON_STALE   = 2'd1,
    REASON_PAUSED  = 2'd2,
    REASON_TRIGGER = 2'd3
  } reason_t;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_STOP_DISTANCE = 3'd0;
  localparam cfg_idx_t REG_PAUSE_TICKS   = 3'd1;
  localparam cfg_idx_t REG_COOLDOWN      = 3'd2;
  localparam cfg_idx_t REG_SCAN_TIMEOUT  = 3'd3;
  localparam cfg_idx_t REG_CMD_TIMEOUT   = 3'd4;

  typedef logic signed [CMD_W-1:0] cmd_word_t;

endpackage

// ===== design/obstacle_pause_velocity_gate_top.sv =====
// Velocity gate: front and back scan samples, commands and ticks arrive on one input channel.
// One item can be accepted in every clock, except while a tick is held off. Only a tick
// produces a result, registered in the cycle after acceptance. A tick is held off only while
// the previous result still sits in the stalled output register; samples and commands are
// still accepted then. The nearest obstacle of each scan is committed on its last sample, and
// the output is zeroed when any source is stale, while a pause runs, and on the tick that
// starts a pause. Configuration writes are taken at any time (cfg_ready is tied high) and
// should only be issued while the block is idle.
module obstacle_pause_velocity_gate_top
  import obpvg_pkg::*;
#(
  parameter int TIMER_BITS = 20,
  parameter int RANGE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_kind,
  input  logic [RANGE_BITS-1:0] in_range_mm,
  input  logic                  in_range_finite,
  input  logic [RANGE_BITS-1:0] in_range_lo_mm,
  input  logic [RANGE_BITS-1:0] in_range_hi_mm,
  input  logic                  in_end_of_scan,
  input  logic signed [31:0]    in_cmd_lin_x,
  input  logic signed [31:0]    in_cmd_lin_y,
  input  logic signed [31:0]    in_cmd_lin_z,
  input  logic signed [31:0]    in_cmd_ang_x,
  input  logic signed [31:0]    in_cmd_ang_y,
  input  logic signed [31:0]    in_cmd_ang_z,

  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [31:0]    out_lin_x,
  output logic signed [31:0]    out_lin_y,
  output logic signed [31:0]    out_lin_z,
  output logic signed [31:0]    out_ang_x,
  output logic signed [31:0]    out_ang_y,
  output logic signed [31:0]    out_ang_z,
  output logic [1:0]            out_gate_reason,

  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [RANGE_BITS-1:0] RANGE_ALL = '1;
  localparam logic [TIMER_BITS-1:0] AGE_ALL   = '1;

  // configuration
  logic [RANGE_BITS-1:0] stop_dist_r;
  logic [TIMER_BITS-1:0] pause_ticks_r, cooldown_r, scan_to_r, cmd_to_r;

  // scan and command state
  logic [RANGE_BITS-1:0] front_run_r, front_run_nxt, back_run_r, back_run_nxt;
  logic [RANGE_BITS-1:0] front_near_r, front_near_nxt, back_near_r, back_near_nxt;
  logic                  front_seen_r, front_seen_nxt, back_seen_r, back_seen_nxt;
  logic                  cmd_seen_r, cmd_seen_nxt;
  logic [TIMER_BITS-1:0] front_age_r, front_age_nxt, back_age_r, back_age_nxt;
  logic [TIMER_BITS-1:0] cmd_age_r, cmd_age_nxt;
  logic [TIMER_BITS-1:0] pause_left_r, pause_left_nxt;
  logic [TIMER_BITS:0]   hold_left_r, hold_left_nxt;
  cmd_word_t             held_cmd_r [NUM_AXES];
  cmd_word_t             in_cmd     [NUM_AXES];

  // result register
  logic                  out_valid_r, out_valid_nxt;
  cmd_word_t             out_cmd_r  [NUM_AXES];
  cmd_word_t             out_cmd_nxt[NUM_AXES];
  reason_t               reason_r, reason_nxt;

  kind_t                 kind;
  logic                  in_fire, tick_fire, cfg_fire;
  logic                  sample_ok, front_hit, back_hit;
  logic [RANGE_BITS-1:0] front_cand, back_cand;
  logic [TIMER_BITS-1:0] pause_dec;
  logic [TIMER_BITS:0]   hold_dec;
  logic                  fresh_all, obstacle, trigger;

  assign kind      = kind_t'(in_kind);
  assign in_stall  = out_valid_r && out_stall && (kind == KIND_TICK);
  assign in_fire   = in_valid && !in_stall;
  assign tick_fire = in_fire && (kind == KIND_TICK);
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  assign in_cmd[0] = in_cmd_lin_x;
  assign in_cmd[1] = in_cmd_lin_y;
  assign in_cmd[2] = in_cmd_lin_z;
  assign in_cmd[3] = in_cmd_ang_x;
  assign in_cmd[4] = in_cmd_ang_y;
  assign in_cmd[5] = in_cmd_ang_z;

  // sample inside the scanner limits; inverted limits reject everything
  assign sample_ok = in_range_finite && (in_range_mm >= in_range_lo_mm)
                     && (in_range_mm <= in_range_hi_mm);
  assign front_hit  = sample_ok && (in_range_mm < front_run_r);
  assign back_hit   = sample_ok && (in_range_mm < back_run_r);
  assign front_cand = front_hit ? in_range_mm : front_run_r;
  assign back_cand  = back_hit ? in_range_mm : back_run_r;

  assign pause_dec = (pause_left_r != '0) ? pause_left_r - 1'b1 : pause_left_r;
  assign hold_dec  = (hold_left_r != '0) ? hold_left_r - 1'b1 : hold_left_r;

  assign fresh_all = front_seen_r && (front_age_r <= scan_to_r)
                     && back_seen_r && (back_age_r <= scan_to_r)
                     && cmd_seen_r && (cmd_age_r <= cmd_to_r);

  // an empty scan commits all ones and never counts as an obstacle
  assign obstacle = ((front_near_r != RANGE_ALL) && (front_near_r <= stop_dist_r))
                    || ((back_near_r != RANGE_ALL) && (back_near_r <= stop_dist_r));

  assign trigger = fresh_all && (pause_dec == '0) && obstacle && (hold_dec == '0);

  always_comb begin
    front_run_nxt  = front_run_r;
    back_run_nxt   = back_run_r;
    front_near_nxt = front_near_r;
    back_near_nxt  = back_near_r;
    front_seen_nxt = front_seen_r;
    back_seen_nxt  = back_seen_r;
    cmd_seen_nxt   = cmd_seen_r;
    front_age_nxt  = front_age_r;
    back_age_nxt   = back_age_r;
    cmd_age_nxt    = cmd_age_r;
    pause_left_nxt = pause_left_r;
    hold_left_nxt  = hold_left_r;
    reason_nxt     = reason_r;
    for (int i = 0; i < NUM_AXES; i++) begin
      out_cmd_nxt[i] = out_cmd_r[i];
    end
    out_valid_nxt = out_valid_r && out_stall;

    if (in_fire) begin
      case (kind)
        KIND_FRONT: begin
          if (in_end_of_scan) begin
            front_near_nxt = front_cand;
            front_run_nxt  = RANGE_ALL;
            front_seen_nxt = 1'b1;
            front_age_nxt  = '0;
          end else begin
            front_run_nxt = front_cand;
          end
        end
        KIND_BACK: begin
          if (in_end_of_scan) begin
            back_near_nxt = back_cand;
            back_run_nxt  = RANGE_ALL;
            back_seen_nxt = 1'b1;
            back_age_nxt  = '0;
          end else begin
            back_run_nxt = back_cand;
          end
        end
        KIND_CMD: begin
          cmd_seen_nxt = 1'b1;
          cmd_age_nxt  = '0;
        end
        default: begin
          pause_left_nxt = pause_dec;
          hold_left_nxt  = hold_dec;
          if (!fresh_all) begin
            reason_nxt = REASON_STALE;
          end else if (pause_dec != '0) begin
            reason_nxt = REASON_PAUSED;
          end else if (trigger) begin
            pause_left_nxt = pause_ticks_r;
            hold_left_nxt  = {1'b0, pause_ticks_r} + {1'b0, cooldown_r};
            reason_nxt     = REASON_TRIGGER;
          end else begin
            reason_nxt = REASON_FORWARD;
          end
          for (int i = 0; i < NUM_AXES; i++) begin
            out_cmd_nxt[i] = (reason_nxt == REASON_FORWARD) ? held_cmd_r[i] : '0;
          end
          out_valid_nxt = 1'b1;
          // ages saturate at all ones, which is stale unless a timeout is set to all ones
          front_age_nxt = (front_age_r == AGE_ALL) ? AGE_ALL : front_age_r + 1'b1;
          back_age_nxt  = (back_age_r == AGE_ALL) ? AGE_ALL : back_age_r + 1'b1;
          cmd_age_nxt   = (cmd_age_r == AGE_ALL) ? AGE_ALL : cmd_age_r + 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_dist_r   <= RANGE_BITS'(800);
      pause_ticks_r <= TIMER_BITS'(200);
      cooldown_r    <= TIMER_BITS'(200);
      scan_to_r     <= TIMER_BITS'(10);
      cmd_to_r      <= TIMER_BITS'(10);
    end else if (cfg_fire) begin
      case (cfg_index)
        REG_STOP_DISTANCE: stop_dist_r   <= cfg_data[RANGE_BITS-1:0];
        REG_PAUSE_TICKS:   pause_ticks_r <= cfg_data[TIMER_BITS-1:0];
        REG_COOLDOWN:      cooldown_r    <= cfg_data[TIMER_BITS-1:0];
        REG_SCAN_TIMEOUT:  scan_to_r     <= cfg_data[TIMER_BITS-1:0];
        REG_CMD_TIMEOUT:   cmd_to_r      <= cfg_data[TIMER_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_run_r  <= RANGE_ALL;
      back_run_r   <= RANGE_ALL;
      front_near_r <= RANGE_ALL;
      back_near_r  <= RANGE_ALL;
      front_seen_r <= 1'b0;
      back_seen_r  <= 1'b0;
      cmd_seen_r   <= 1'b0;
      front_age_r  <= '0;
      back_age_r   <= '0;
      cmd_age_r    <= '0;
      pause_left_r <= '0;
      hold_left_r  <= '0;
      out_valid_r  <= 1'b0;
      reason_r     <= REASON_FORWARD;
      for (int i = 0; i < NUM_AXES; i++) begin
        held_cmd_r[i] <= '0;
      end
    end else begin
      front_run_r  <= front_run_nxt;
      back_run_r   <= back_run_nxt;
      front_near_r <= front_near_nxt;
      back_near_r  <= back_near_nxt;
      front_seen_r <= front_seen_nxt;
      back_seen_r  <= back_seen_nxt;
      cmd_seen_r   <= cmd_seen_nxt;
      front_age_r  <= front_age_nxt;
      back_age_r   <= back_age_nxt;
      cmd_age_r    <= cmd_age_nxt;
      pause_left_r <= pause_left_nxt;
      hold_left_r  <= hold_left_nxt;
      out_valid_r  <= out_valid_nxt;
      reason_r     <= reason_nxt;
      if (in_fire && (kind == KIND_CMD)) begin
        for (int i = 0; i < NUM_AXES; i++) begin
          held_cmd_r[i] <= in_cmd[i];
        end
      end
    end
  end

  // result payload, loaded only when a tick is taken
  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_AXES; i++) begin
      out_cmd_r[i] <= out_cmd_nxt[i];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_lin_x       = out_cmd_r[0];
  assign out_lin_y       = out_cmd_r[1];
  assign out_lin_z       = out_cmd_r[2];
  assign out_ang_x       = out_cmd_r[3];
  assign out_ang_y       = out_cmd_r[4];
  assign out_ang_z       = out_cmd_r[5];
  assign out_gate_reason = reason_r;

`ifndef NO_ASSERTIONS
  // the no-trigger window always covers the pause
  a_hold_covers_pause: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, pause_left_r} <= hold_left_r)
    else $error("hold_left below pause_left");

  // a gated result carries zero velocity
  a_gated_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (reason_r != REASON_FORWARD)) |->
      ((out_lin_x == '0) && (out_lin_y == '0) && (out_lin_z == '0)
       && (out_ang_x == '0) && (out_ang_y == '0) && (out_ang_z == '0)))
    else $error("gated result with nonzero velocity");

  // a trigger loads the full pause length
  a_trigger_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (tick_fire && trigger) |=> (pause_left_r == $past(pause_ticks_r))
      && (reason_r == REASON_TRIGGER))
    else $error("trigger did not load pause timer");

  // every accepted tick gives a result in the next cycle
  a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
    tick_fire |=> out_valid_r)
    else $error("tick without result");
`endif

endmodule

// ===== verif/obstacle_pause_velocity_gate_top_tb.sv =====
module obstacle_pause_velocity_gate_top_tb
  import obpvg_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANGE_W       = 16;
  localparam int TIMER_W       = 20;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 4;

  typedef struct packed {
    kind_t                          kind;
    logic [RANGE_W-1:0]             range_mm;
    logic                           finite;
    logic [RANGE_W-1:0]             lo_mm;
    logic [RANGE_W-1:0]             hi_mm;
    logic                           eos;
    logic [NUM_AXES-1:0][CMD_W-1:0] vel;
  } gate_beat_t;

  typedef struct packed {
    logic [NUM_AXES-1:0][CMD_W-1:0] vel;
    reason_t                        reason;
  } gate_out_t;

  class velocity_gate_sb;
    logic [RANGE_W-1:0]             stop_mm;
    logic [TIMER_W-1:0]             pause_len, cool_len, scan_limit, cmd_limit;
    logic [RANGE_W-1:0]             front_run, back_run, front_near, back_near;
    bit                             front_seen, back_seen, cmd_seen;
    logic [TIMER_W-1:0]             front_age, back_age, cmd_age;
    logic [TIMER_W:0]               pause_left, hold_left;
    logic [NUM_AXES-1:0][CMD_W-1:0] held_cmd;
    gate_out_t                      expected_outputs[$];
    int                             mismatches, beats_seen, outputs_checked;
    int                             reason_hits[4];

    function new();
      stop_mm    = 16'd800;
      pause_len  = 20'd200;
      cool_len   = 20'd200;
      scan_limit = 20'd10;
      cmd_limit  = 20'd10;
      front_run  = '1;
      back_run   = '1;
      front_near = '1;
      back_near  = '1;
      front_seen = 1'b0;
      back_seen  = 1'b0;
      cmd_seen   = 1'b0;
      front_age  = '0;
      back_age   = '0;
      cmd_age    = '0;
      pause_left = '0;
      hold_left  = '0;
      held_cmd   = '0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_STOP_DISTANCE: stop_mm    = data[RANGE_W-1:0];
        REG_PAUSE_TICKS:   pause_len  = data[TIMER_W-1:0];
        REG_COOLDOWN:      cool_len   = data[TIMER_W-1:0];
        REG_SCAN_TIMEOUT:  scan_limit = data[TIMER_W-1:0];
        REG_CMD_TIMEOUT:   cmd_limit  = data[TIMER_W-1:0];
        default: ;
      endcase
    endfunction

    // an empty scan reads all ones and never counts as an obstacle
    function bit is_obstacle(logic [RANGE_W-1:0] nearest);
      return nearest != '1 && nearest <= stop_mm;
    endfunction

    function logic [TIMER_W-1:0] age_up(logic [TIMER_W-1:0] a);
      return (a == '1) ? a : a + 1'b1;
    endfunction

    function void note_beat(gate_beat_t b);
      logic [RANGE_W-1:0] run;
      bit                 fresh;
      gate_out_t          o;
      beats_seen++;
      case (b.kind)
        KIND_FRONT, KIND_BACK: begin
          run = (b.kind == KIND_FRONT) ? front_run : back_run;
          if (b.finite && b.range_mm >= b.lo_mm && b.range_mm <= b.hi_mm && b.range_mm < run)
            run = b.range_mm;
          if (b.kind == KIND_FRONT) begin
            if (b.eos) begin
              front_near = run;
              front_seen = 1'b1;
              front_age  = '0;
              run        = '1;
            end
            front_run = run;
          end else begin
            if (b.eos) begin
              back_near = run;
              back_seen = 1'b1;
              back_age  = '0;
              run       = '1;
            end
            back_run = run;
          end
        end
        KIND_CMD: begin
          held_cmd = b.vel;
          cmd_seen = 1'b1;
          cmd_age  = '0;
        end
        default: begin
          if (pause_left != '0) pause_left = pause_left - 1'b1;
          if (hold_left != '0) hold_left = hold_left - 1'b1;
          fresh = front_seen && front_age <= scan_limit &&
                  back_seen && back_age <= scan_limit &&
                  cmd_seen && cmd_age <= cmd_limit;
          o.vel = '0;
          if (!fresh) begin
            o.reason = REASON_STALE;
          end else if (pause_left != '0) begin
            o.reason = REASON_PAUSED;
          end else if ((is_obstacle(front_near) || is_obstacle(back_near)) &&
                       hold_left == '0) begin
            pause_left = {1'b0, pause_len};
            hold_left  = {1'b0, pause_len} + {1'b0, cool_len};
            o.reason   = REASON_TRIGGER;
          end else begin
            o.reason = REASON_FORWARD;
            o.vel    = held_cmd;
          end
          front_age = age_up(front_age);
          back_age  = age_up(back_age);
          cmd_age   = age_up(cmd_age);
          expected_outputs.push_back(o);
        end
      endcase
    endfunction

    task report_mismatch(string what);
      mismatches++;
      if (mismatches <= 40) $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_output(gate_out_t got);
      gate_out_t want;
      outputs_checked++;
      if (expected_outputs.size() == 0) begin
        report_mismatch($sformatf("gate output %0d with nothing expected", outputs_checked));
        return;
      end
      want = expected_outputs.pop_front();
      for (int a = 0; a < NUM_AXES; a++) begin
        if (got.vel[a] !== want.vel[a])
          report_mismatch($sformatf("output %0d axis %0d: got %0d, want %0d", outputs_checked,
                                    a, $signed(got.vel[a]), $signed(want.vel[a])));
      end
      if (got.reason !== want.reason)
        report_mismatch($sformatf("output %0d reason: got %0d, want %0d", outputs_checked,
                                  got.reason, want.reason));
      reason_hits[int'(want.reason)]++;
    endtask

    function int pending();
      return expected_outputs.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [1:0]            in_kind = '0;
  logic [RANGE_W-1:0]    in_range_mm = '0;
  logic                  in_range_finite = 1'b0;
  logic [RANGE_W-1:0]    in_range_lo_mm = '0;
  logic [RANGE_W-1:0]    in_range_hi_mm = '0;
  logic                  in_end_of_scan = 1'b0;
  logic signed [31:0]    in_cmd_lin_x = '0;
  logic signed [31:0]    in_cmd_lin_y = '0;
  logic signed [31:0]    in_cmd_lin_z = '0;
  logic signed [31:0]    in_cmd_ang_x = '0;
  logic signed [31:0]    in_cmd_ang_y = '0;
  logic signed [31:0]    in_cmd_ang_z = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic signed [31:0]    out_lin_x, out_lin_y, out_lin_z;
  logic signed [31:0]    out_ang_x, out_ang_y, out_ang_z;
  logic [1:0]            out_gate_reason;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  velocity_gate_sb sb = new();
  int              items_sent = 0;
  int              cur_stop = 800;
  bit              no_gaps = 1'b0;
  int              stall_left = 0;
  int              cycle_count = 0;

  obstacle_pause_velocity_gate_top #(
    .TIMER_BITS (TIMER_W),
    .RANGE_BITS (RANGE_W)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_range_mm     (in_range_mm),
    .in_range_finite (in_range_finite),
    .in_range_lo_mm  (in_range_lo_mm),
    .in_range_hi_mm  (in_range_hi_mm),
    .in_end_of_scan  (in_end_of_scan),
    .in_cmd_lin_x    (in_cmd_lin_x),
    .in_cmd_lin_y    (in_cmd_lin_y),
    .in_cmd_lin_z    (in_cmd_lin_z),
    .in_cmd_ang_x    (in_cmd_ang_x),
    .in_cmd_ang_y    (in_cmd_ang_y),
    .in_cmd_ang_z    (in_cmd_ang_z),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_lin_x       (out_lin_x),
    .out_lin_y       (out_lin_y),
    .out_lin_z       (out_lin_z),
    .out_ang_x       (out_ang_x),
    .out_ang_y       (out_ang_y),
    .out_ang_z       (out_ang_z),
    .out_gate_reason (out_gate_reason),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("no completion within %0d cycles, %0d gate outputs outstanding",
               CYCLE_LIMIT, sb.pending());
      $display("simulation failed");
      $finish;
    end
  end

  // receiver back-pressure: mostly short runs, some long stalls, some clear stretches
  always @(posedge clk) begin : stall_gen
    int roll;
    if (stall_left > 0) begin
      stall_left--;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 50) begin
        out_stall  <= 1'b0;
        stall_left = $urandom_range(0, 5);
      end else if (roll < 82) begin
        out_stall  <= 1'b1;
        stall_left = $urandom_range(0, 2);
      end else if (roll < 92) begin
        out_stall  <= 1'b1;
        stall_left = $urandom_range(3, 20);
      end else begin
        out_stall  <= 1'b0;
        stall_left = $urandom_range(20, 80);
      end
    end
  end

  always @(posedge clk) begin : monitor
    gate_beat_t b;
    gate_out_t  o;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        o.vel[0] = out_lin_x;
        o.vel[1] = out_lin_y;
        o.vel[2] = out_lin_z;
        o.vel[3] = out_ang_x;
        o.vel[4] = out_ang_y;
        o.vel[5] = out_ang_z;
        o.reason = reason_t'(out_gate_reason);
        sb.check_output(o);
      end
      if (in_valid && !in_stall) begin
        b.kind     = kind_t'(in_kind);
        b.range_mm = in_range_mm;
        b.finite   = in_range_finite;
        b.lo_mm    = in_range_lo_mm;
        b.hi_mm    = in_range_hi_mm;
        b.eos      = in_end_of_scan;
        b.vel[0]   = in_cmd_lin_x;
        b.vel[1]   = in_cmd_lin_y;
        b.vel[2]   = in_cmd_lin_z;
        b.vel[3]   = in_cmd_ang_x;
        b.vel[4]   = in_cmd_ang_y;
        b.vel[5]   = in_cmd_ang_z;
        sb.note_beat(b);
      end
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
    end
  end

  function automatic gate_beat_t noise_beat();
    gate_beat_t b;
    b.kind     = kind_t'($urandom_range(0, 3));
    b.range_mm = RANGE_W'($urandom());
    b.finite   = 1'($urandom_range(0, 1));
    b.lo_mm    = RANGE_W'($urandom());
    b.hi_mm    = RANGE_W'($urandom());
    b.eos      = 1'($urandom_range(0, 1));
    for (int a = 0; a < NUM_AXES; a++) b.vel[a] = $urandom();
    return b;
  endfunction

  function automatic gate_beat_t tick_beat();
    gate_beat_t b;
    b      = noise_beat();
    b.kind = KIND_TICK;
    return b;
  endfunction

  function automatic gate_beat_t scan_beat(kind_t k, logic [RANGE_W-1:0] r, logic fin,
                                           logic [RANGE_W-1:0] lo, logic [RANGE_W-1:0] hi,
                                           logic eos);
    gate_beat_t b;
    b          = noise_beat();
    b.kind     = k;
    b.range_mm = r;
    b.finite   = fin;
    b.lo_mm    = lo;
    b.hi_mm    = hi;
    b.eos      = eos;
    return b;
  endfunction

  function automatic gate_beat_t cmd_beat();
    gate_beat_t b;
    b      = noise_beat();
    b.kind = KIND_CMD;
    for (int a = 0; a < NUM_AXES; a++) begin
      case ($urandom_range(0, 7))
        0: b.vel[a] = 32'h8000_0000;
        1: b.vel[a] = 32'h7FFF_FFFF;
        2: b.vel[a] = '0;
        3: b.vel[a] = '1;
        default: ;
      endcase
    end
    return b;
  endfunction

  // readings cluster around the stop distance so both sides of the compare get hit
  function automatic logic [RANGE_W-1:0] pick_range();
    int roll;
    int v;
    roll = $urandom_range(0, 99);
    if (roll < 40)      v = cur_stop + int'($urandom_range(0, 80)) - 40;
    else if (roll < 55) v = int'($urandom_range(0, 65535));
    else if (roll < 63) v = 0;
    else if (roll < 71) v = 65535;
    else                v = cur_stop + int'($urandom_range(1, 3000));
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return RANGE_W'(v);
  endfunction

  task automatic push_beat(gate_beat_t b);
    int roll;
    int gap;
    roll = $urandom_range(0, 99);
    if (no_gaps || roll < 60) gap = 0;
    else if (roll < 92)       gap = $urandom_range(1, 3);
    else                      gap = $urandom_range(4, 25);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_kind         <= b.kind;
    in_range_mm     <= b.range_mm;
    in_range_finite <= b.finite;
    in_range_lo_mm  <= b.lo_mm;
    in_range_hi_mm  <= b.hi_mm;
    in_end_of_scan  <= b.eos;
    in_cmd_lin_x    <= b.vel[0];
    in_cmd_lin_y    <= b.vel[1];
    in_cmd_lin_z    <= b.vel[2];
    in_cmd_ang_x    <= b.vel[3];
    in_cmd_ang_y    <= b.vel[4];
    in_cmd_ang_z    <= b.vel[5];
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic send_scan(kind_t k);
    int                 n;
    int                 roll;
    logic [RANGE_W-1:0] r, lo, hi;
    n = $urandom_range(1, 5);
    for (int i = 0; i < n; i++) begin
      r    = pick_range();
      roll = $urandom_range(0, 99);
      if (roll < 75) begin
        lo = RANGE_W'($urandom_range(0, 30));
        hi = ($urandom_range(0, 3) == 0) ? '1 : RANGE_W'($urandom_range(40000, 65535));
      end else if (roll < 90) begin
        // window closed onto the reading itself
        lo = r;
        hi = r;
      end else begin
        lo = RANGE_W'($urandom());
        hi = RANGE_W'($urandom());
      end
      push_beat(scan_beat(k, r, $urandom_range(0, 9) != 0, lo, hi, i == n - 1));
    end
  endtask

  task automatic run_frames(int count);
    int goal;
    int ticks;
    goal = items_sent + count;
    while (items_sent < goal) begin
      if ($urandom_range(0, 99) < 85) begin
        no_gaps = ($urandom_range(0, 7) == 0);
        if ($urandom_range(0, 7) != 0) send_scan(KIND_FRONT);
        if ($urandom_range(0, 7) != 0) send_scan(KIND_BACK);
        if ($urandom_range(0, 5) != 0) push_beat(cmd_beat());
        ticks = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 16) : $urandom_range(1, 4);
        repeat (ticks) push_beat(tick_beat());
      end else begin
        no_gaps = 1'b0;
        repeat ($urandom_range(1, 3)) push_beat(noise_beat());
      end
    end
    no_gaps = 1'b0;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // unused upper data bits carry noise, the register must keep only its own width
  task automatic write_cfg(cfg_idx_t idx, logic [31:0] value, logic [31:0] mask);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= ($urandom() & ~mask) | (value & mask);
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_settings(logic [31:0] stop, logic [31:0] pause, logic [31:0] cool,
                                logic [31:0] scan_to, logic [31:0] cmd_to);
    settle();
    write_cfg(REG_STOP_DISTANCE, stop, 32'h0000_FFFF);
    write_cfg(REG_PAUSE_TICKS, pause, 32'h000F_FFFF);
    write_cfg(REG_COOLDOWN, cool, 32'h000F_FFFF);
    write_cfg(REG_SCAN_TIMEOUT, scan_to, 32'h000F_FFFF);
    write_cfg(REG_CMD_TIMEOUT, cmd_to, 32'h000F_FFFF);
    // stray write past the last register must change nothing
    write_cfg(cfg_idx_t'($urandom_range(int'(REG_CMD_TIMEOUT) + 1, (1 << CFG_IDX_W) - 1)),
              $urandom(), '1);
    cfg_valid <= 1'b0;
    cur_stop = int'(stop[RANGE_W-1:0]);
  endtask

  initial begin
    gate_beat_t b;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: nothing seen yet, obstacle one above the stop distance
    push_beat(tick_beat());
    push_beat(scan_beat(KIND_FRONT, 16'd801, 1'b1, 16'd0, 16'hFFFF, 1'b0));
    push_beat(scan_beat(KIND_FRONT, 16'hFFFF, 1'b1, 16'd0, 16'hFFFF, 1'b1));
    push_beat(scan_beat(KIND_BACK, 16'd100, 1'b1, 16'd200, 16'd50, 1'b1));
    b        = cmd_beat();
    b.vel[0] = 32'h8000_0000;
    b.vel[1] = 32'h7FFF_FFFF;
    b.vel[2] = '1;
    b.vel[3] = '0;
    b.vel[4] = 32'h0000_0001;
    b.vel[5] = 32'h5555_AAAA;
    push_beat(b);
    push_beat(tick_beat());
    push_beat(scan_beat(KIND_BACK, 16'd0, 1'b0, 16'd0, 16'hFFFF, 1'b1));
    push_beat(tick_beat());

    // zero-length pause: a triggered zero output, a forwarded one in cooldown, a second trigger, then stale
    apply_settings(800, 0, 2, 2, 2);
    push_beat(scan_beat(KIND_FRONT, 16'd0, 1'b1, 16'd0, 16'd0, 1'b1));
    push_beat(scan_beat(KIND_BACK, 16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF, 1'b1));
    push_beat(cmd_beat());
    repeat (5) push_beat(tick_beat());

    apply_settings(1000, 0, 4, 6, 6);
    run_frames(150);
    apply_settings(500, 3, 5, 3, 4);
    run_frames(160);
    apply_settings(0, 1, 0, 0, 0);
    run_frames(160);
    apply_settings(65535, 2, 2, 8, 8);
    run_frames(160);
    apply_settings(2000, 5, 10, 12, 12);
    run_frames(160);
    // widest timers last, a pause here never ends
    apply_settings(65534, 20'hFFFFF, 20'hFFFFF, 20'hFFFFE, 20'hFFFFE);
    run_frames(140);
    settle();

    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d gate outputs never arrived", sb.pending()));
    $display("covered %0d input beats and %0d gate outputs across eight register settings",
             sb.beats_seen, sb.outputs_checked);
    $display("outputs by reason: forwarded %0d, stale %0d, paused %0d, triggered %0d",
             sb.reason_hits[0], sb.reason_hits[1], sb.reason_hits[2], sb.reason_hits[3]);
    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
